>>> hdl/arcr_pkg.sv
`timescale 1ns / 1ps
package arcr_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int PAGE_BITS  = 31;
  localparam int FRAME_W    = 6;
  localparam int CFG_W      = 7;
  localparam int AW         = $clog2(MAX_FRAMES);
  localparam int CW         = $clog2(MAX_FRAMES + 1);
  localparam int NLISTS     = 4;
  localparam int LAW        = $clog2(NLISTS * MAX_FRAMES);

  typedef enum logic [1:0] {
    FN_ACCESS = 2'd0,
    FN_SETEV  = 2'd1,
    FN_REMOVE = 2'd2,
    FN_EVICT  = 2'd3
  } arcr_func_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_NOT_LIVE = 2'd1,
    ERR_PINNED   = 2'd2
  } arcr_err_t;

  // list ids inside the shared list memory
  typedef enum logic [1:0] {
    L_REC  = 2'd0,
    L_FREQ = 2'd1,
    L_RG   = 2'd2,
    L_FG   = 2'd3
  } arcr_list_t;

  typedef enum logic [1:0] {
    LOC_NONE = 2'd0,
    LOC_REC  = 2'd1,
    LOC_FREQ = 2'd2
  } arcr_loc_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_FIND, S_DROP,
    S_A_MOVE, S_A_PUSHF, S_A_RG, S_A_FG, S_A_DIV, S_A_REVIVE, S_A_MISS,
    S_R_DROP, S_R_FIN,
    S_EV_L, S_EV_T, S_EV_C, S_EV_G,
    S_G_RG, S_G_FG0, S_G_FG, S_G_SEL, S_G_PUSH,
    S_DONE
  } arcr_state_t;

  typedef struct packed {
    arcr_func_t             func;
    logic [FRAME_W-1:0]     frame;
    logic [PAGE_BITS-1:0]   page;
    logic                   make_evictable;
  } arcr_in_t;

  typedef struct packed {
    logic                   victim_valid;
    logic [FRAME_W-1:0]     victim_frame;
    arcr_err_t              error;
    logic [CFG_W-1:0]       evictable_count;
  } arcr_out_t;

  typedef struct packed {
    arcr_loc_t              loc;
    logic                   evict;
    logic [PAGE_BITS-1:0]   page;
  } arcr_ft_t;

  localparam int FT_W = $bits(arcr_ft_t);

  typedef struct packed {
    logic                   we;
    logic [LAW-1:0]         waddr;
    logic [PAGE_BITS-1:0]   wdata;
    logic [LAW-1:0]         raddr;
  } arcr_lm_req_t;

  typedef struct packed {
    logic                   we;
    logic [AW-1:0]          waddr;
    arcr_ft_t               wdata;
    logic [AW-1:0]          raddr;
  } arcr_ft_req_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(MAX_FRAMES)) s = s - (CW+1)'(MAX_FRAMES);
    return s[AW-1:0];
  endfunction

  function automatic logic [LAW-1:0] lm_addr(input arcr_list_t lid,
                                             input logic [AW-1:0] phys);
    return LAW'(lid) * LAW'(MAX_FRAMES) + LAW'(phys);
  endfunction

  function automatic logic [CW-1:0] cap_clamp(input logic [CFG_W-1:0] raw);
    logic [CW-1:0] c;
    if (raw == '0) c = CW'(1);
    else if (CW'(raw) > CW'(MAX_FRAMES)) c = CW'(MAX_FRAMES);
    else c = CW'(raw);
    return c;
  endfunction

  function automatic arcr_list_t loc_list(input arcr_loc_t loc);
    return (loc == LOC_FREQ) ? L_FREQ : L_REC;
  endfunction

endpackage

>>> hdl/arcr_ram.sv
`timescale 1ns / 1ps
module arcr_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/arcr_div.sv
`timescale 1ns / 1ps
module arcr_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [arcr_pkg::CW-1:0] num,
  input  logic [arcr_pkg::CW-1:0] den,
  output logic                   busy,
  output logic [arcr_pkg::CW-1:0] quot
);
  import arcr_pkg::*;

  localparam int NW = $clog2(CW + 1);

  logic          busy_r, busy_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [CW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [CW:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      n_r    <= n_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[CW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = NW'(CW);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[CW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CW-1:0];
        quo_nxt = {quo_r[CW-2:0], 1'b0};
      end
      n_nxt = n_r - 1'b1;
      if (n_r == NW'(1)) busy_nxt = 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
endmodule

>>> hdl/arcr_ctrl.sv
`timescale 1ns / 1ps
module arcr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  arcr_pkg::arcr_in_t        in_data,
  output logic                      in_stall,
  input  logic [arcr_pkg::CW-1:0]   cap,
  output logic                      res_valid,
  output arcr_pkg::arcr_out_t       res_data,
  input  logic                      res_take,
  output arcr_pkg::arcr_lm_req_t    lm_req,
  input  logic [arcr_pkg::PAGE_BITS-1:0] lm_rdata,
  output arcr_pkg::arcr_ft_req_t    ft_req,
  input  arcr_pkg::arcr_ft_t        ft_rdata
);
  import arcr_pkg::*;

  arcr_state_t state_r, state_nxt, ret_r, ret_nxt;
  arcr_list_t  lsel_r, lsel_nxt, glist_r, glist_nxt;
  arcr_func_t  func_r, func_nxt;
  arcr_err_t   rerr_r, rerr_nxt;
  arcr_loc_t   loc_r, loc_nxt;

  logic [AW-1:0]        head_r [NLISTS];
  logic [AW-1:0]        head_nxt [NLISTS];
  logic [CW-1:0]        cnt_r [NLISTS];
  logic [CW-1:0]        cnt_nxt [NLISTS];
  logic [MAX_FRAMES-1:0] ftv_r, ftv_nxt;
  logic [AW-1:0]        ftra_r;

  logic [CW-1:0]        sidx_r, sidx_nxt, pidx_r, pidx_nxt, fidx_r, fidx_nxt;
  logic [CW-1:0]        target_r, target_nxt, live_r, live_nxt;
  logic                 pend_r, pend_nxt, found_r, found_nxt, first_r, first_nxt;
  logic                 up_r, up_nxt, mk_r, mk_nxt, ev_r, ev_nxt, rvalid_r, rvalid_nxt;
  logic [AW-1:0]        frame_r, frame_nxt, vframe_r, vframe_nxt, rframe_r, rframe_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt, fpage_r, fpage_nxt, key_r, key_nxt;

  logic [AW-1:0]        cur_head, scan_phys, gh;
  logic [CW-1:0]        cur_cnt, d, gn;
  logic [CW:0]          tsum;
  logic [CW+1:0]        sum2, sum4;
  logic                 match;
  arcr_ft_t             ftq;

  logic                 div_start, div_busy;
  logic [CW-1:0]        div_num, div_den, div_quot;

  arcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ftv_r    <= '0;
      target_r <= '0;
      live_r   <= '0;
      pend_r   <= 1'b0;
      for (int i = 0; i < NLISTS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ftv_r    <= ftv_nxt;
      target_r <= target_nxt;
      live_r   <= live_nxt;
      pend_r   <= pend_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
    end
    ret_r    <= ret_nxt;
    lsel_r   <= lsel_nxt;
    glist_r  <= glist_nxt;
    func_r   <= func_nxt;
    rerr_r   <= rerr_nxt;
    loc_r    <= loc_nxt;
    ftra_r   <= ft_req.raddr;
    sidx_r   <= sidx_nxt;
    pidx_r   <= pidx_nxt;
    fidx_r   <= fidx_nxt;
    found_r  <= found_nxt;
    first_r  <= first_nxt;
    up_r     <= up_nxt;
    mk_r     <= mk_nxt;
    ev_r     <= ev_nxt;
    rvalid_r <= rvalid_nxt;
    frame_r  <= frame_nxt;
    vframe_r <= vframe_nxt;
    rframe_r <= rframe_nxt;
    page_r   <= page_nxt;
    fpage_r  <= fpage_nxt;
    key_r    <= key_nxt;
  end

  assign cur_head  = head_r[lsel_r];
  assign cur_cnt   = cnt_r[lsel_r];
  assign scan_phys = wrap_add(cur_head, sidx_r);
  assign match     = pend_r && (lm_rdata == key_r);
  // an entry never written reads as not live, pinned
  assign ftq       = ftv_r[ftra_r] ? ft_rdata : arcr_ft_t'{LOC_NONE, 1'b0, '0};
  assign sum2      = (CW+2)'(cnt_r[L_REC]) + (CW+2)'(cnt_r[L_RG]);
  assign sum4      = sum2 + (CW+2)'(cnt_r[L_FREQ]) + (CW+2)'(cnt_r[L_FG]);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    lsel_nxt   = lsel_r;
    glist_nxt  = glist_r;
    func_nxt   = func_r;
    rerr_nxt   = rerr_r;
    loc_nxt    = loc_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    ftv_nxt    = ftv_r;
    sidx_nxt   = sidx_r;
    pidx_nxt   = pidx_r;
    fidx_nxt   = fidx_r;
    target_nxt = target_r;
    live_nxt   = live_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    first_nxt  = first_r;
    up_nxt     = up_r;
    mk_nxt     = mk_r;
    ev_nxt     = ev_r;
    rvalid_nxt = rvalid_r;
    frame_nxt  = frame_r;
    vframe_nxt = vframe_r;
    rframe_nxt = rframe_r;
    page_nxt   = page_r;
    fpage_nxt  = fpage_r;
    key_nxt    = key_r;
    lm_req     = '{1'b0, '0, '0, '0};
    ft_req     = '{1'b0, frame_r, '{LOC_NONE, 1'b0, '0}, frame_r};
    div_start  = 1'b0;
    div_num    = cnt_r[L_FG];
    div_den    = cnt_r[L_RG];
    res_valid  = 1'b0;
    d          = CW'(1);
    tsum       = '0;
    gh         = '0;
    gn         = '0;

    unique case (state_r)
      S_IDLE: begin
        ft_req.raddr = AW'(in_data.frame);
        if (in_valid) begin
          func_nxt   = in_data.func;
          frame_nxt  = AW'(in_data.frame);
          page_nxt   = in_data.page;
          mk_nxt     = in_data.make_evictable;
          rvalid_nxt = 1'b0;
          rframe_nxt = '0;
          rerr_nxt   = ERR_OK;
          state_nxt  = S_DEC;
        end
      end

      S_DEC: begin
        loc_nxt   = ftq.loc;
        ev_nxt    = ftq.evict;
        fpage_nxt = ftq.page;
        sidx_nxt  = '0;
        pend_nxt  = 1'b0;
        unique case (func_r)
          FN_ACCESS: begin
            state_nxt = S_FIND;
            if (ftq.loc != LOC_NONE) begin
              lsel_nxt = loc_list(ftq.loc);
              key_nxt  = PAGE_BITS'(frame_r);
              ret_nxt  = S_A_MOVE;
            end else begin
              lsel_nxt = L_RG;
              key_nxt  = page_r;
              ret_nxt  = S_A_RG;
            end
          end
          FN_SETEV: begin
            state_nxt = S_DONE;
            if (ftq.loc == LOC_NONE) begin
              rerr_nxt = ERR_NOT_LIVE;
            end else if (ftq.evict != mk_r) begin
              ft_req.we    = 1'b1;
              ft_req.wdata = '{ftq.loc, mk_r, ftq.page};
              ftv_nxt[frame_r] = 1'b1;
              live_nxt = mk_r ? live_r + 1'b1 : live_r - 1'b1;
            end
          end
          FN_REMOVE: begin
            if (ftq.loc == LOC_NONE) begin
              state_nxt = S_DONE;
            end else if (!ftq.evict) begin
              rerr_nxt  = ERR_PINNED;
              state_nxt = S_DONE;
            end else begin
              lsel_nxt  = loc_list(ftq.loc);
              key_nxt   = PAGE_BITS'(frame_r);
              ret_nxt   = S_R_DROP;
              state_nxt = S_FIND;
            end
          end
          FN_EVICT: begin
            lsel_nxt  = (cnt_r[L_REC] >= target_r) ? L_REC : L_FREQ;
            first_nxt = 1'b1;
            state_nxt = S_EV_L;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // scan one list for key, one entry a cycle, oldest first
      S_FIND: begin
        lm_req.raddr = lm_addr(lsel_r, scan_phys);
        if (match) begin
          found_nxt = 1'b1;
          fidx_nxt  = pidx_r;
          pend_nxt  = 1'b0;
          state_nxt = ret_r;
        end else if (sidx_r == cur_cnt) begin
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = ret_r;
        end else begin
          pend_nxt = 1'b1;
          pidx_nxt = sidx_r;
          sidx_nxt = sidx_r + 1'b1;
        end
      end

      // close the gap at fidx: move each newer entry down by one
      S_DROP: begin
        lm_req.raddr = lm_addr(lsel_r, scan_phys);
        if (pend_r) begin
          lm_req.we    = 1'b1;
          lm_req.waddr = lm_addr(lsel_r, wrap_add(cur_head, pidx_r));
          lm_req.wdata = lm_rdata;
        end
        if (sidx_r < cur_cnt) begin
          pend_nxt = 1'b1;
          pidx_nxt = sidx_r;
          sidx_nxt = sidx_r + 1'b1;
          if (pend_r) pidx_nxt = sidx_r - 1'b1;
          else pidx_nxt = sidx_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cnt_nxt[lsel_r] = cur_cnt - 1'b1;
            state_nxt = ret_r;
          end
        end
      end

      S_A_MOVE: begin
        sidx_nxt  = fidx_r + 1'b1;
        pend_nxt  = 1'b0;
        ret_nxt   = S_A_PUSHF;
        state_nxt = S_DROP;
      end

      S_A_PUSHF: begin
        lm_req.we    = 1'b1;
        lm_req.waddr = lm_addr(L_FREQ, wrap_add(head_r[L_FREQ], cnt_r[L_FREQ]));
        lm_req.wdata = PAGE_BITS'(frame_r);
        cnt_nxt[L_FREQ] = cnt_r[L_FREQ] + 1'b1;
        ft_req.we    = 1'b1;
        ft_req.wdata = '{LOC_FREQ, ev_r, fpage_r};
        ftv_nxt[frame_r] = 1'b1;
        state_nxt    = S_DONE;
      end

      S_A_RG: begin
        if (found_r) begin
          up_nxt    = 1'b1;
          div_start = 1'b1;
          state_nxt = S_A_DIV;
        end else begin
          lsel_nxt  = L_FG;
          sidx_nxt  = '0;
          pend_nxt  = 1'b0;
          ret_nxt   = S_A_FG;
          state_nxt = S_FIND;
        end
      end

      S_A_FG: begin
        if (found_r) begin
          up_nxt    = 1'b0;
          div_start = 1'b1;
          div_num   = cnt_r[L_RG];
          div_den   = cnt_r[L_FG];
          state_nxt = S_A_DIV;
        end else begin
          state_nxt = S_A_MISS;
        end
      end

      // adapt the target once the ghost length ratio is known
      S_A_DIV: begin
        if (!div_busy) begin
          if (up_r) begin
            if (cnt_r[L_RG] < cnt_r[L_FG]) d = div_quot;
            tsum = (CW+1)'(target_r) + (CW+1)'(d);
            target_nxt = (tsum > (CW+1)'(cap)) ? cap : CW'(tsum);
          end else begin
            if (cnt_r[L_FG] < cnt_r[L_RG]) d = div_quot;
            target_nxt = (target_r >= d) ? target_r - d : '0;
          end
          sidx_nxt  = fidx_r + 1'b1;
          pend_nxt  = 1'b0;
          ret_nxt   = S_A_REVIVE;
          state_nxt = S_DROP;
        end
      end

      S_A_REVIVE: begin
        lm_req.we    = 1'b1;
        lm_req.waddr = lm_addr(L_FREQ, wrap_add(head_r[L_FREQ], cnt_r[L_FREQ]));
        lm_req.wdata = PAGE_BITS'(frame_r);
        cnt_nxt[L_FREQ] = cnt_r[L_FREQ] + 1'b1;
        ft_req.we    = 1'b1;
        ft_req.wdata = '{LOC_FREQ, 1'b1, page_r};
        ftv_nxt[frame_r] = 1'b1;
        live_nxt     = live_r + 1'b1;
        state_nxt    = S_DONE;
      end

      // miss: trim one ghost tail if the lists are full, insert as recent
      S_A_MISS: begin
        if (sum2 == (CW+2)'(cap)) begin
          if (cnt_r[L_RG] != '0) begin
            head_nxt[L_RG] = wrap_add(head_r[L_RG], CW'(1));
            cnt_nxt[L_RG]  = cnt_r[L_RG] - 1'b1;
          end
        end else if (sum4 == {1'b0, cap, 1'b0}) begin
          if (cnt_r[L_FG] != '0) begin
            head_nxt[L_FG] = wrap_add(head_r[L_FG], CW'(1));
            cnt_nxt[L_FG]  = cnt_r[L_FG] - 1'b1;
          end
        end
        lm_req.we    = 1'b1;
        lm_req.waddr = lm_addr(L_REC, wrap_add(head_r[L_REC], cnt_r[L_REC]));
        lm_req.wdata = PAGE_BITS'(frame_r);
        cnt_nxt[L_REC] = cnt_r[L_REC] + 1'b1;
        ft_req.we    = 1'b1;
        ft_req.wdata = '{LOC_REC, 1'b1, page_r};
        ftv_nxt[frame_r] = 1'b1;
        live_nxt     = live_r + 1'b1;
        state_nxt    = S_DONE;
      end

      S_R_DROP: begin
        sidx_nxt  = fidx_r + 1'b1;
        pend_nxt  = 1'b0;
        ret_nxt   = S_R_FIN;
        state_nxt = S_DROP;
      end

      S_R_FIN: begin
        ft_req.we    = 1'b1;
        ft_req.wdata = '{LOC_NONE, 1'b0, fpage_r};
        ftv_nxt[frame_r] = 1'b1;
        live_nxt     = live_r - 1'b1;
        state_nxt    = S_DONE;
      end

      // victim search: list entry, then its frame record
      S_EV_L: begin
        lm_req.raddr = lm_addr(lsel_r, scan_phys);
        if (sidx_r == cur_cnt) begin
          if (first_r) begin
            lsel_nxt  = (lsel_r == L_REC) ? L_FREQ : L_REC;
            first_nxt = 1'b0;
            sidx_nxt  = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_EV_T;
        end
      end

      S_EV_T: begin
        vframe_nxt   = lm_rdata[AW-1:0];
        ft_req.raddr = lm_rdata[AW-1:0];
        state_nxt    = S_EV_C;
      end

      S_EV_C: begin
        if (ftq.evict) begin
          fidx_nxt     = sidx_r;
          fpage_nxt    = ftq.page;
          ft_req.we    = 1'b1;
          ft_req.waddr = vframe_r;
          ft_req.wdata = '{LOC_NONE, 1'b0, ftq.page};
          ftv_nxt[vframe_r] = 1'b1;
          live_nxt     = live_r - 1'b1;
          rvalid_nxt   = 1'b1;
          rframe_nxt   = vframe_r;
          glist_nxt    = (lsel_r == L_REC) ? L_RG : L_FG;
          sidx_nxt     = sidx_r + 1'b1;
          pend_nxt     = 1'b0;
          ret_nxt      = S_EV_G;
          state_nxt    = S_DROP;
        end else begin
          sidx_nxt  = sidx_r + 1'b1;
          state_nxt = S_EV_L;
        end
      end

      // the victim's page leaves both ghost lists before its push
      S_EV_G: begin
        lsel_nxt  = L_RG;
        key_nxt   = fpage_r;
        sidx_nxt  = '0;
        pend_nxt  = 1'b0;
        ret_nxt   = S_G_RG;
        state_nxt = S_FIND;
      end

      S_G_RG: begin
        sidx_nxt = fidx_r + 1'b1;
        pend_nxt = 1'b0;
        ret_nxt  = S_G_FG0;
        state_nxt = found_r ? S_DROP : S_G_FG0;
      end

      S_G_FG0: begin
        lsel_nxt  = L_FG;
        sidx_nxt  = '0;
        pend_nxt  = 1'b0;
        ret_nxt   = S_G_FG;
        state_nxt = S_FIND;
      end

      S_G_FG: begin
        sidx_nxt  = fidx_r + 1'b1;
        pend_nxt  = 1'b0;
        ret_nxt   = S_G_SEL;
        state_nxt = found_r ? S_DROP : S_G_SEL;
      end

      S_G_SEL: begin
        lsel_nxt  = glist_r;
        state_nxt = S_G_PUSH;
      end

      // drop oldest ghosts until below capacity, then push the page
      S_G_PUSH: begin
        gh = cur_head;
        gn = cur_cnt;
        if (cur_cnt >= cap) begin
          gh = wrap_add(cur_head, cur_cnt - cap + 1'b1);
          gn = cap - 1'b1;
        end
        head_nxt[lsel_r] = gh;
        cnt_nxt[lsel_r]  = gn + 1'b1;
        lm_req.we    = 1'b1;
        lm_req.waddr = lm_addr(lsel_r, wrap_add(gh, gn));
        lm_req.wdata = fpage_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign res_data = '{rvalid_r, FRAME_W'(rframe_r), rerr_r, CFG_W'(live_r)};
endmodule

>>> hdl/arc_page_replacer.sv
`timescale 1ns / 1ps
// Port group   Direction  Handshake          Payload
// in_*         input      in_valid/in_stall  arcr_in_t (func, frame, page, make_evictable)
// out_*        output     out_valid/out_stall arcr_out_t (victim, error, evictable count)
// cfg_*        input      cfg_we             capacity, 7 bits
//
// One word at a time. A word's run time grows with its list work: a scan walks
// the entries one by one, a shift moves each newer entry, an evict scan checks
// entries until it finds an evictable one, and a ghost hit waits on the divider.
// The single read port of the list memory sets this cost.
// Reset is synchronous; no clearing pass, frame records carry valid flops.
// A result waits in the output register while the next word is accepted.
module arc_page_replacer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  arcr_pkg::arcr_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output arcr_pkg::arcr_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [arcr_pkg::CFG_W-1:0] cfg_wdata
);
  import arcr_pkg::*;

  logic [CFG_W-1:0]     cap_r;
  logic                 out_valid_r;
  arcr_out_t            out_data_r;
  logic                 res_valid, res_take;
  arcr_out_t            res_data;
  arcr_lm_req_t         lm_req;
  arcr_ft_req_t         ft_req;
  logic [PAGE_BITS-1:0] lm_rdata;
  logic [FT_W-1:0]      ft_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CFG_W'(MAX_FRAMES);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (res_valid && res_take) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (res_valid && res_take) out_data_r <= res_data;
  end

  assign res_take  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  arcr_ram #(.W(PAGE_BITS), .D(NLISTS * MAX_FRAMES)) u_list_ram (
    .clk   (clk),
    .we    (lm_req.we),
    .waddr (lm_req.waddr),
    .wdata (lm_req.wdata),
    .raddr (lm_req.raddr),
    .rdata (lm_rdata)
  );

  arcr_ram #(.W(FT_W), .D(MAX_FRAMES)) u_frame_ram (
    .clk   (clk),
    .we    (ft_req.we),
    .waddr (ft_req.waddr),
    .wdata (ft_req.wdata),
    .raddr (ft_req.raddr),
    .rdata (ft_rdata)
  );

  arcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cap       (cap_clamp(cap_r)),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .lm_req    (lm_req),
    .lm_rdata  (lm_rdata),
    .ft_req    (ft_req),
    .ft_rdata  (arcr_ft_t'(ft_rdata))
  );
endmodule
